/* rtl/dnd_pkg.sv */
// Shared types and constants for the DNS name decompressor.
// Holds the microcode ROM, the control word and the sequencer flag types.
// No dependencies.
package dnd_pkg;

  localparam int STEP_W = 3;

  // Microprogram addresses
  localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_RD_LEN = 3'd1;
  localparam logic [STEP_W-1:0] STEP_LEN    = 3'd2;
  localparam logic [STEP_W-1:0] STEP_PTR    = 3'd3;
  localparam logic [STEP_W-1:0] STEP_CHR_RD = 3'd4;
  localparam logic [STEP_W-1:0] STEP_CHR    = 3'd5;
  localparam logic [STEP_W-1:0] STEP_DOT    = 3'd6;
  localparam logic [STEP_W-1:0] STEP_FIN    = 3'd7;

  localparam logic       OP_LOAD   = 1'b0;
  localparam logic       OP_DECODE = 1'b1;
  localparam logic [7:0] PTR_TAG   = 8'd192;
  localparam logic [7:0] DOT_CHAR  = 8'h2E;

  typedef enum logic [2:0] {
    UOP_IDLE   = 3'd0,
    UOP_RD_LEN = 3'd1,
    UOP_LEN    = 3'd2,
    UOP_PTR    = 3'd3,
    UOP_CHR_RD = 3'd4,
    UOP_CHR    = 3'd5,
    UOP_DOT    = 3'd6,
    UOP_FIN    = 3'd7
  } uop_t;

  typedef struct packed {
    uop_t              uop;
    logic [STEP_W-1:0] nxt;
    logic [STEP_W-1:0] alt;
  } ctrl_word_t;

  typedef struct packed {
    logic hold;
    logic jump;
    logic fin;
  } seq_flags_t;

  function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    case (step)
      STEP_IDLE:   w = '{UOP_IDLE,   STEP_IDLE,   STEP_RD_LEN};
      STEP_RD_LEN: w = '{UOP_RD_LEN, STEP_LEN,    STEP_LEN};
      STEP_LEN:    w = '{UOP_LEN,    STEP_CHR_RD, STEP_PTR};
      STEP_PTR:    w = '{UOP_PTR,    STEP_RD_LEN, STEP_RD_LEN};
      STEP_CHR_RD: w = '{UOP_CHR_RD, STEP_CHR,    STEP_CHR};
      STEP_CHR:    w = '{UOP_CHR,    STEP_CHR_RD, STEP_DOT};
      STEP_DOT:    w = '{UOP_DOT,    STEP_RD_LEN, STEP_RD_LEN};
      STEP_FIN:    w = '{UOP_FIN,    STEP_IDLE,   STEP_IDLE};
      default:     w = '{UOP_IDLE,   STEP_IDLE,   STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* rtl/dnd_store.sv */
// Packet byte store: one write port, one registered read port.
// Depends on nothing; sized by PKT_DEPTH.
module dnd_store #(
  parameter int PKT_DEPTH = 512,
  parameter int AW        = $clog2(PKT_DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [PKT_DEPTH];

  // read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/dnd_seq.sv */
// Microcode sequencer: step counter plus ROM lookup with conditional jumps.
// Depends on dnd_pkg.
module dnd_seq import dnd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  seq_flags_t flags,
  output ctrl_word_t cw
);

  logic [STEP_W-1:0] step_r, step_nxt;

  assign cw = ucode(step_r);

  always_comb begin
    step_nxt = cw.nxt;
    if (flags.hold) begin
      step_nxt = step_r;
    end else if (flags.fin) begin
      step_nxt = STEP_FIN;
    end else if (flags.jump) begin
      step_nxt = cw.alt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

/* rtl/dnd_dp.sv */
// Walk datapath: position and label counters, chunk packer, result register.
// Depends on dnd_pkg; driven by the micro-op from dnd_seq.
module dnd_dp import dnd_pkg::*; #(
  parameter int PKT_DEPTH      = 512,
  parameter int MAX_NAME_CHARS = 255,
  parameter int AW             = $clog2(PKT_DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  uop_t          uop,
  output seq_flags_t    flags,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_opcode,
  input  logic [8:0]    in_address,
  input  logic [7:0]    in_data_byte,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  input  logic [7:0]    rd_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_char_a,
  output logic [7:0]    out_char_b,
  output logic [7:0]    out_char_c,
  output logic [7:0]    out_char_d,
  output logic [2:0]    out_valid_chars,
  output logic          out_last,
  output logic [8:0]    out_consumed,
  output logic          out_status
);

  localparam int PW = ((AW > 14) ? AW : 14) + 1;
  localparam int JW = $clog2(PKT_DEPTH + 2);
  localparam logic [PW-1:0] DEPTH_P = PW'(PKT_DEPTH);
  localparam logic [JW-1:0] DEPTH_J = JW'(PKT_DEPTH);
  localparam logic [7:0]    MAX_C   = 8'(MAX_NAME_CHARS);

  logic [PW-1:0]   pos_r, pos_nxt;
  logic [8:0]      start_r, start_nxt;
  logic [7:0]      cnt_r, cnt_nxt;
  logic [5:0]      hi_r, hi_nxt;
  logic            jumped_r, jumped_nxt;
  logic [JW-1:0]   jumps_r, jumps_nxt;
  logic [7:0]      nchars_r, nchars_nxt;
  logic            err_r, err_nxt;
  logic [8:0]      cons_r, cons_nxt;
  logic [3:0][7:0] ch_r, ch_nxt;
  logic [2:0]      nch_r, nch_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [3:0][7:0] out_ch_r, out_ch_nxt;
  logic [2:0]      out_vc_r, out_vc_nxt;
  logic            out_last_r, out_last_nxt;
  logic [8:0]      out_cons_r, out_cons_nxt;
  logic            out_stat_r, out_stat_nxt;

  logic [PW-1:0] addr_ext, pos_inc;
  logic [13:0]   ptr_off;
  logic          out_free, push, push_hold, emit, emit_last;
  logic [7:0]    push_char;

  assign addr_ext  = PW'(in_address);
  assign pos_inc   = pos_r + PW'(1);
  assign ptr_off   = {hi_r, rd_data};
  assign out_free  = !out_valid_r || out_ready;
  assign push_hold = (nch_r == 3'd4) && !out_free;
  assign in_ready  = (uop == UOP_IDLE);
  assign wr_addr   = addr_ext[AW-1:0];
  assign wr_data   = in_data_byte;

  always_comb begin
    pos_nxt    = pos_r;
    start_nxt  = start_r;
    cnt_nxt    = cnt_r;
    hi_nxt     = hi_r;
    jumped_nxt = jumped_r;
    jumps_nxt  = jumps_r;
    nchars_nxt = nchars_r;
    err_nxt    = err_r;
    cons_nxt   = cons_r;
    ch_nxt     = ch_r;
    nch_nxt    = nch_r;
    flags      = '0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = pos_r[AW-1:0];
    push       = 1'b0;
    push_char  = '0;
    emit       = 1'b0;
    emit_last  = 1'b0;

    case (uop)
      UOP_IDLE: begin
        if (in_valid) begin
          if (in_opcode == OP_LOAD) begin
            wr_en = (addr_ext < DEPTH_P);
          end else begin
            pos_nxt    = addr_ext;
            start_nxt  = in_address;
            jumped_nxt = 1'b0;
            jumps_nxt  = '0;
            nchars_nxt = '0;
            err_nxt    = 1'b0;
            cons_nxt   = '0;
            ch_nxt     = '0;
            nch_nxt    = '0;
            flags.jump = 1'b1;
          end
        end
      end
      UOP_RD_LEN: begin
        if (pos_r >= DEPTH_P) begin
          err_nxt   = 1'b1;
          flags.fin = 1'b1;
        end else begin
          rd_en = 1'b1;
        end
      end
      UOP_LEN: begin
        if (rd_data == 8'd0) begin
          if (!jumped_r) begin
            cons_nxt = 9'(pos_r - PW'(start_r) + PW'(1));
          end
          flags.fin = 1'b1;
        end else if (rd_data >= PTR_TAG) begin
          if (pos_inc >= DEPTH_P) begin
            err_nxt   = 1'b1;
            flags.fin = 1'b1;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = pos_inc[AW-1:0];
            hi_nxt     = rd_data[5:0];
            flags.jump = 1'b1;
          end
        end else begin
          cnt_nxt = rd_data;
          pos_nxt = pos_inc;
        end
      end
      UOP_PTR: begin
        if (!jumped_r) begin
          cons_nxt   = 9'(pos_r - PW'(start_r) + PW'(2));
          jumped_nxt = 1'b1;
        end
        jumps_nxt = jumps_r + JW'(1);
        if ((PW'(ptr_off) >= DEPTH_P) || (jumps_r >= DEPTH_J)) begin
          err_nxt   = 1'b1;
          flags.fin = 1'b1;
        end else begin
          pos_nxt = PW'(ptr_off);
        end
      end
      UOP_CHR_RD: begin
        if ((pos_r >= DEPTH_P) || (nchars_r >= MAX_C)) begin
          err_nxt   = 1'b1;
          flags.fin = 1'b1;
        end else begin
          rd_en = 1'b1;
        end
      end
      UOP_CHR: begin
        push      = 1'b1;
        push_char = rd_data;
        if (!push_hold) begin
          nchars_nxt = nchars_r + 8'd1;
          pos_nxt    = pos_inc;
          cnt_nxt    = cnt_r - 8'd1;
          if (cnt_r == 8'd1) begin
            flags.jump = 1'b1;
          end
        end
      end
      UOP_DOT: begin
        if (nchars_r >= MAX_C) begin
          err_nxt   = 1'b1;
          flags.fin = 1'b1;
        end else begin
          push      = 1'b1;
          push_char = DOT_CHAR;
          if (!push_hold) begin
            nchars_nxt = nchars_r + 8'd1;
          end
        end
      end
      UOP_FIN: begin
        if (!out_free) begin
          flags.hold = 1'b1;
        end else begin
          emit      = 1'b1;
          emit_last = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // a full chunk goes out only once a fifth character shows it is not the last
    if (push) begin
      if (push_hold) begin
        flags.hold = 1'b1;
      end else if (nch_r == 3'd4) begin
        emit      = 1'b1;
        ch_nxt    = '0;
        ch_nxt[0] = push_char;
        nch_nxt   = 3'd1;
      end else begin
        ch_nxt[nch_r[1:0]] = push_char;
        nch_nxt            = nch_r + 3'd1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_ch_nxt    = out_ch_r;
    out_vc_nxt    = out_vc_r;
    out_last_nxt  = out_last_r;
    out_cons_nxt  = out_cons_r;
    out_stat_nxt  = out_stat_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_ch_nxt    = ch_r;
      out_vc_nxt    = nch_r;
      out_last_nxt  = emit_last;
      out_cons_nxt  = (emit_last && !err_r) ? cons_r : 9'd0;
      out_stat_nxt  = emit_last && err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    start_r    <= start_nxt;
    cnt_r      <= cnt_nxt;
    hi_r       <= hi_nxt;
    jumped_r   <= jumped_nxt;
    jumps_r    <= jumps_nxt;
    nchars_r   <= nchars_nxt;
    err_r      <= err_nxt;
    cons_r     <= cons_nxt;
    ch_r       <= ch_nxt;
    nch_r      <= nch_nxt;
    out_ch_r   <= out_ch_nxt;
    out_vc_r   <= out_vc_nxt;
    out_last_r <= out_last_nxt;
    out_cons_r <= out_cons_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_char_a      = out_ch_r[0];
  assign out_char_b      = out_ch_r[1];
  assign out_char_c      = out_ch_r[2];
  assign out_char_d      = out_ch_r[3];
  assign out_valid_chars = out_vc_r;
  assign out_last        = out_last_r;
  assign out_consumed    = out_cons_r;
  assign out_status      = out_stat_r;

endmodule

/* rtl/dns_name_decompressor.sv */
// DNS name decompressor top level. A load beat writes one in-range store byte. A decode
// beat is accepted, then each length byte (terminator included) is read, each pointer
// followed, each label character is packed, a dot follows each label, and the last beat
// is sent; a stalled result beat waits. One item at a time; the store's single read
// port sets the pace. Reset clears the sequencer and the result valid; store contents
// stay undefined. Depends on dnd_pkg, dnd_store, dnd_seq, dnd_dp.
module dns_name_decompressor import dnd_pkg::*; #(
  parameter int PKT_DEPTH      = 512,
  parameter int MAX_NAME_CHARS = 255
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_opcode,
  input  logic [8:0] in_address,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char_a,
  output logic [7:0] out_char_b,
  output logic [7:0] out_char_c,
  output logic [7:0] out_char_d,
  output logic [2:0] out_valid_chars,
  output logic       out_last,
  output logic [8:0] out_consumed,
  output logic       out_status
);

  localparam int AW = $clog2(PKT_DEPTH);

  // store port wiring
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;

  // sequencer <-> datapath
  ctrl_word_t cw;
  seq_flags_t flags;

  dnd_store #(
    .PKT_DEPTH (PKT_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The ROM step advances, holds on a stalled result beat, takes its alternate step on
  // a decode, pointer or label end, or goes to the finish step on a terminator or error.
  dnd_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .cw    (cw)
  );

  // Characters pack four to a beat; a full chunk waits until the next
  // character proves it is not the final beat.
  dnd_dp #(
    .PKT_DEPTH      (PKT_DEPTH),
    .MAX_NAME_CHARS (MAX_NAME_CHARS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .uop             (cw.uop),
    .flags           (flags),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_address      (in_address),
    .in_data_byte    (in_data_byte),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char_a      (out_char_a),
    .out_char_b      (out_char_b),
    .out_char_c      (out_char_c),
    .out_char_d      (out_char_d),
    .out_valid_chars (out_valid_chars),
    .out_last        (out_last),
    .out_consumed    (out_consumed),
    .out_status      (out_status)
  );

  // only the final beat of a decode may be short
  a_full_mid_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_valid_chars == 3'd4))
    else $error("non-final beat with fewer than four characters");

  a_err_no_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_last && (out_consumed == 9'd0)))
    else $error("error beat reports consumed bytes or is not final");

  a_no_read_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !rd_en)
    else $error("store read issued while idle");

  a_write_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (in_valid && in_ready && (in_opcode == OP_LOAD)))
    else $error("store write without an accepted load beat");

endmodule
